// ===== design/cbiquad_pkg.sv =====
// Shared constants for the cascaded biquad filter: formats, item kinds and register map.
`timescale 1ns / 1ps

package cbiquad_pkg;

    localparam int MAX_STAGES_DEF = 8;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 20;

    localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;
    localparam int COEF_FRAC   = COEF_BITS - 4;
    localparam int DELAY_FRAC  = 2 * SAMPLE_FRAC;
    localparam int PROD_SHIFT  = COEF_FRAC - SAMPLE_FRAC;
    localparam int DELAY_W     = 40;

    localparam int KIND_W     = 2;
    localparam int STAGE_IN_W = 3;
    localparam int SEL_W      = 3;
    localparam int ACTIVE_W   = 4;
    localparam int NUM_COEFS  = 5;

    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COEF   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_ACTIVE_STAGES = 1'b0;

endpackage

// ===== design/cascaded_biquad_iir_filter_top.sv =====
// Cascaded biquad IIR filter (transposed direct form II) with coefficient and delay memories.
`timescale 1ns / 1ps

// A sample item is accepted, runs each active section in turn through the load, product,
// output and z1/z2 update phases, and ends with a result load; its run is paced by the single
// shared multiplier and the one read port of the coefficient memory, which hands out one
// coefficient per cycle. Coefficient-write and clear items finish in the idle state and give
// no result. Items are taken only while the sequencer is idle; the result register lets
// the next item start while a finished result still waits to be taken. Reset needs no
// clearing pass: per-entry valid bits make unwritten coefficients and delays read as zero,
// and a clear item drops all delay valid bits at once.
module cascaded_biquad_iir_filter_top #(
    parameter int MAX_STAGES = cbiquad_pkg::MAX_STAGES_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [cbiquad_pkg::PADDR_W-1:0]             paddr,
    input  logic [cbiquad_pkg::PDATA_W-1:0]             pwdata,
    output logic [cbiquad_pkg::PDATA_W-1:0]             prdata,
    output logic                                        pready,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic [cbiquad_pkg::KIND_W-1:0]              kind,
    input  logic signed [cbiquad_pkg::SAMPLE_BITS-1:0]  sample_in,
    input  logic [cbiquad_pkg::STAGE_IN_W-1:0]          stage_index,
    input  logic [cbiquad_pkg::SEL_W-1:0]               coef_select,
    input  logic signed [cbiquad_pkg::COEF_BITS-1:0]    coef_value,
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic signed [cbiquad_pkg::SAMPLE_BITS-1:0]  sample_out,
    output logic                                        saturated
);

    localparam int SB         = cbiquad_pkg::SAMPLE_BITS;
    localparam int CB         = cbiquad_pkg::COEF_BITS;
    localparam int DW         = cbiquad_pkg::DELAY_W;
    localparam int SEL_W      = cbiquad_pkg::SEL_W;
    localparam int STAGE_W    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int COEF_AW    = STAGE_W + SEL_W;
    localparam int COEF_DEPTH = MAX_STAGES * (2 ** SEL_W);
    localparam int PROD_W     = CB + SB;
    localparam int PPW        = PROD_W - cbiquad_pkg::PROD_SHIFT;
    localparam int ACC_W      = DW + 1;
    localparam int ZW         = DW + 1;
    localparam int RND        = cbiquad_pkg::DELAY_FRAC - cbiquad_pkg::SAMPLE_FRAC;
    localparam int RND_HALF   = 1 << (RND - 1);

    localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'((1 << (SB - 1)) - 1);
    localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

    // phase n fetches coefficient n of the section and consumes the one fetched before
    localparam logic [SEL_W-1:0] PH_LOAD = 3'd0;
    localparam logic [SEL_W-1:0] PH_P0   = 3'd1;
    localparam logic [SEL_W-1:0] PH_OUT  = 3'd2;
    localparam logic [SEL_W-1:0] PH_Z1A  = 3'd3;
    localparam logic [SEL_W-1:0] PH_Z2A  = 3'd4;
    localparam logic [SEL_W-1:0] PH_Z1B  = 3'd5;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t                    state_reg;
    logic [SEL_W-1:0]          ph_reg;
    logic [STAGE_W-1:0]        stage_reg;
    logic [STAGE_W-1:0]        last_reg;
    logic [STAGE_W-1:0]        wb_stage_reg;
    logic                      wb_pending_reg;
    logic [cbiquad_pkg::ACTIVE_W-1:0] active_reg;
    logic [COEF_DEPTH-1:0]     cvalid_reg;
    logic [MAX_STAGES-1:0]     dvalid_reg;
    logic                      out_valid_reg;
    logic signed [SB-1:0]      sample_out_reg;
    logic                      saturated_reg;

    logic signed [SB-1:0]      x_reg;
    logic signed [SB-1:0]      y_reg;
    logic                      clip_reg;
    logic signed [PPW-1:0]     prod_reg;
    logic signed [ZW-1:0]      z1part_reg;
    logic signed [PPW-1:0]     z2part_reg;
    logic signed [DW-1:0]      z1new_reg;

    logic signed [CB-1:0]      coef_mem [COEF_DEPTH];
    logic signed [CB-1:0]      coef_rd_reg;
    logic                      coef_rv_reg;
    logic [2*DW-1:0]           delay_mem [MAX_STAGES];
    logic [2*DW-1:0]           delay_rd_reg;
    logic                      delay_rv_reg;

    logic                      cfg_wr;
    logic                      in_acc;
    logic                      run;
    logic                      coef_we;
    logic [COEF_AW-1:0]        coef_waddr;
    logic [COEF_AW-1:0]        coef_raddr;
    logic [STAGE_W-1:0]        last_calc;
    logic signed [CB-1:0]      coef_op;
    logic signed [SB-1:0]      mul_op;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [PPW-1:0]     prod_sh;
    logic signed [DW-1:0]      z1_q;
    logic signed [DW-1:0]      z2_q;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   rnd;
    logic signed [SB-1:0]      y_sat;
    logic                      y_clip;
    logic signed [DW-1:0]      z2new;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[cbiquad_pkg::PADDR_W-1:2] == cbiquad_pkg::REG_ACTIVE_STAGES)
                  ? cbiquad_pkg::PDATA_W'(active_reg) : '0;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign run      = (state_reg == ST_RUN);

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign saturated  = saturated_reg;

    assign coef_we    = in_acc && (kind == cbiquad_pkg::KIND_COEF)
                     && (int'(coef_select) < cbiquad_pkg::NUM_COEFS)
                     && (int'(stage_index) < MAX_STAGES);
    assign coef_waddr = {STAGE_W'(stage_index), coef_select};
    assign coef_raddr = {stage_reg, ph_reg};

    always_comb
    begin
        if (active_reg == '0)
            last_calc = '0;
        else if (int'(active_reg) > MAX_STAGES)
            last_calc = STAGE_W'(MAX_STAGES - 1);
        else
            last_calc = STAGE_W'(active_reg - 1'b1);
    end

    // shared multiplier and section arithmetic
    always_comb
    begin
        coef_op   = coef_rv_reg ? coef_rd_reg : '0;
        mul_op    = (ph_reg == PH_Z2A || ph_reg == PH_Z1B) ? y_reg : x_reg;
        prod_full = PROD_W'(coef_op) * PROD_W'(mul_op);
        prod_sh   = PPW'(prod_full >>> cbiquad_pkg::PROD_SHIFT);

        z1_q = delay_rv_reg ? $signed(delay_rd_reg[2*DW-1:DW]) : '0;
        z2_q = delay_rv_reg ? $signed(delay_rd_reg[DW-1:0]) : '0;

        acc = ACC_W'(prod_reg) + ACC_W'(z1_q);
        rnd = (acc + ACC_W'(RND_HALF)) >>> RND;
        if (rnd > Y_MAX)
        begin
            y_sat  = SB'(Y_MAX);
            y_clip = 1'b1;
        end
        else if (rnd < Y_MIN)
        begin
            y_sat  = SB'(Y_MIN);
            y_clip = 1'b1;
        end
        else
        begin
            y_sat  = SB'(rnd);
            y_clip = 1'b0;
        end

        z2new = DW'(ZW'(z2part_reg) - ZW'(prod_reg));
    end

    // sequencer, valid bits and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ph_reg         <= PH_LOAD;
            stage_reg      <= '0;
            last_reg       <= '0;
            wb_stage_reg   <= '0;
            wb_pending_reg <= 1'b0;
            active_reg     <= cbiquad_pkg::ACTIVE_W'(1);
            cvalid_reg     <= '0;
            dvalid_reg     <= '0;
            out_valid_reg  <= 1'b0;
            sample_out_reg <= '0;
            saturated_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr && paddr[cbiquad_pkg::PADDR_W-1:2] == cbiquad_pkg::REG_ACTIVE_STAGES)
                active_reg <= pwdata[cbiquad_pkg::ACTIVE_W-1:0];

            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;

            if (wb_pending_reg)
            begin
                dvalid_reg[wb_stage_reg] <= 1'b1;
                wb_pending_reg           <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        unique case (kind)
                            cbiquad_pkg::KIND_SAMPLE:
                            begin
                                stage_reg <= '0;
                                ph_reg    <= PH_LOAD;
                                last_reg  <= last_calc;
                                state_reg <= ST_RUN;
                            end
                            cbiquad_pkg::KIND_COEF:
                            begin
                                if (coef_we)
                                    cvalid_reg[coef_waddr] <= 1'b1;
                            end
                            cbiquad_pkg::KIND_CLEAR:
                            begin
                                dvalid_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_RUN:
                begin
                    if (ph_reg == PH_Z1B)
                    begin
                        wb_pending_reg <= 1'b1;
                        wb_stage_reg   <= stage_reg;
                        ph_reg         <= PH_LOAD;
                        if (stage_reg == last_reg)
                            state_reg <= ST_DONE;
                        else
                            stage_reg <= stage_reg + 1'b1;
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        sample_out_reg <= x_reg;
                        saturated_reg  <= clip_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // section datapath
    always_ff @(posedge clk)
    begin
        if (in_acc && kind == cbiquad_pkg::KIND_SAMPLE)
        begin
            x_reg    <= sample_in;
            clip_reg <= 1'b0;
        end
        if (run)
        begin
            case (ph_reg)
                PH_P0:
                begin
                    prod_reg <= prod_sh;
                end
                PH_OUT:
                begin
                    y_reg    <= y_sat;
                    clip_reg <= clip_reg | y_clip;
                    prod_reg <= prod_sh;
                end
                PH_Z1A:
                begin
                    z1part_reg <= ZW'(z2_q) + ZW'(prod_reg);
                    prod_reg   <= prod_sh;
                end
                PH_Z2A:
                begin
                    z2part_reg <= prod_reg;
                    prod_reg   <= prod_sh;
                end
                PH_Z1B:
                begin
                    z1new_reg <= DW'(z1part_reg - ZW'(prod_reg));
                    prod_reg  <= prod_sh;
                    x_reg     <= y_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // coefficient memory
    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_waddr] <= coef_value;
        coef_rd_reg <= coef_mem[coef_raddr];
        coef_rv_reg <= cvalid_reg[coef_raddr];
    end

    // delay memory: {z1, z2} per section
    always_ff @(posedge clk)
    begin
        if (wb_pending_reg)
            delay_mem[wb_stage_reg] <= {z1new_reg, z2new};
        if (run && ph_reg == PH_LOAD)
        begin
            delay_rd_reg <= delay_mem[stage_reg];
            delay_rv_reg <= dvalid_reg[stage_reg];
        end
    end

endmodule

// ===== design/cbiquad_checker.sv =====
// Port-level checks for the cascaded biquad filter, bound to the top level.
`timescale 1ns / 1ps

module cbiquad_checker (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  logic                                        in_stall,
    input  logic [cbiquad_pkg::KIND_W-1:0]              kind,
    input  logic                                        out_valid,
    input  logic                                        out_stall,
    input  logic signed [cbiquad_pkg::SAMPLE_BITS-1:0]  sample_out,
    input  logic                                        saturated
);

    logic in_acc;

    assign in_acc = in_valid && !in_stall;

    // a sample item leaves the input stalled once it has been accepted
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && kind == cbiquad_pkg::KIND_SAMPLE |=> in_stall)
        else $error("sample item did not occupy the sequencer");

    // non-sample items leave the input free again in the next cycle
    a_ctrl_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && kind != cbiquad_pkg::KIND_SAMPLE |=> !in_stall)
        else $error("control item held the input");

    // non-sample items never produce a result
    a_ctrl_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && kind != cbiquad_pkg::KIND_SAMPLE && !out_valid |=> !out_valid)
        else $error("result appeared for a control item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(saturated))
        else $error("stalled result changed");

endmodule

bind cascaded_biquad_iir_filter_top cbiquad_checker u_cbiquad_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .saturated  (saturated)
);

// ===== verif/cascaded_biquad_iir_filter_top_tb.sv =====
// Self-checking testbench for the cascaded biquad filter: directed rows, then random phases.
`timescale 1ns / 1ps

module cascaded_biquad_iir_filter_top_tb;

    localparam int KIND_W      = cbiquad_pkg::KIND_W;
    localparam int SEL_W       = cbiquad_pkg::SEL_W;
    localparam int PADDR_W     = cbiquad_pkg::PADDR_W;
    localparam int PDATA_W     = cbiquad_pkg::PDATA_W;
    localparam int STAGE_IN_W  = cbiquad_pkg::STAGE_IN_W;
    localparam int ACTIVE_W    = cbiquad_pkg::ACTIVE_W;
    localparam int SAMPLE_BITS = cbiquad_pkg::SAMPLE_BITS;
    localparam int COEF_BITS   = cbiquad_pkg::COEF_BITS;
    localparam int SAMPLE_FRAC = cbiquad_pkg::SAMPLE_FRAC;
    localparam int DELAY_FRAC  = cbiquad_pkg::DELAY_FRAC;
    localparam int PROD_SHIFT  = cbiquad_pkg::PROD_SHIFT;
    localparam int NUM_COEFS   = cbiquad_pkg::NUM_COEFS;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = cbiquad_pkg::KIND_SAMPLE;
    localparam logic [KIND_W-1:0] KIND_COEF   = cbiquad_pkg::KIND_COEF;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = cbiquad_pkg::KIND_CLEAR;

    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
    localparam logic [SEL_W-1:0]  SEL_B0  = 3'd0;
    localparam logic [SEL_W-1:0]  SEL_B1  = 3'd1;
    localparam logic [SEL_W-1:0]  SEL_B2  = 3'd2;
    localparam logic [SEL_W-1:0]  SEL_A1  = 3'd3;
    localparam logic [SEL_W-1:0]  SEL_A2  = 3'd4;
    localparam logic [SEL_W-1:0]  SEL_TOP = 3'd7;
    localparam logic [PADDR_W-1:0] ADDR_ACTIVE_STAGES =
        PADDR_W'(4 * cbiquad_pkg::REG_ACTIVE_STAGES);
    localparam logic [PADDR_W-1:0] ADDR_UNUSED        = PADDR_W'(4);

    localparam int STAGES         = cbiquad_pkg::MAX_STAGES_DEF;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 240;
    localparam int SETTLE_CYCLES  = 6 * STAGES + 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ROUND_SHIFT    = DELAY_FRAC - SAMPLE_FRAC;
    localparam longint HALF_LSB   = longint'(1) << (ROUND_SHIFT - 1);
    localparam longint OUT_MAX    = (longint'(1) << SAMPLE_FRAC) - 1;
    localparam longint OUT_MIN    = -(longint'(1) << SAMPLE_FRAC);

    typedef struct {
        logic [KIND_W-1:0]             kind;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic [STAGE_IN_W-1:0]         stage;
        logic [SEL_W-1:0]              sel;
        logic signed [COEF_BITS-1:0]   value;
        bit                            typed;
        logic signed [SAMPLE_BITS-1:0] want;
        logic                          want_sat;
    } stim_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          sat;
    } filtered_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [PADDR_W-1:0]            paddr = '0;
    logic [PDATA_W-1:0]            pwdata = '0;
    logic [PDATA_W-1:0]            prdata;
    logic                          pready;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [KIND_W-1:0]             kind = KIND_SAMPLE;
    logic signed [SAMPLE_BITS-1:0] sample_in = '0;
    logic [STAGE_IN_W-1:0]         stage_index = '0;
    logic [SEL_W-1:0]              coef_select = SEL_B0;
    logic signed [COEF_BITS-1:0]   coef_value = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          saturated;

    longint          coef_mem [STAGES][NUM_COEFS];
    longint          state_z1 [STAGES];
    longint          state_z2 [STAGES];
    logic [ACTIVE_W-1:0] stage_cfg;
    filtered_t       pending_q [$];
    stim_t           directed_rows [$];
    int              failures = 0;
    int              burst_left = 0;
    int              idle_cycles = 0;
    int              stall_mode = 0;
    int              mode_left = 0;
    int              hold_left = 0;

    cascaded_biquad_iir_filter_top uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .sample_in(sample_in), .stage_index(stage_index),
        .coef_select(coef_select), .coef_value(coef_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .sample_out(sample_out), .saturated(saturated)
    );

    always #10 clk = ~clk;

    function automatic longint scaled_product(input longint c, input longint x);
        return (c * x) >>> PROD_SHIFT;
    endfunction

    function automatic filtered_t filter_sample(input logic signed [SAMPLE_BITS-1:0] x_in);
        filtered_t r;
        int        n;
        longint    x;
        longint    acc;
        longint    y;
        n = int'(stage_cfg);
        if (n == 0)
            n = 1;
        if (n > STAGES)
            n = STAGES;
        x = longint'(x_in);
        r.sat = 1'b0;
        for (int s = 0; s < n; s++)
        begin
            acc = scaled_product(coef_mem[s][SEL_B0], x) + state_z1[s];
            y = (acc + HALF_LSB) >>> ROUND_SHIFT;
            if (y > OUT_MAX)
            begin
                y = OUT_MAX;
                r.sat = 1'b1;
            end
            else if (y < OUT_MIN)
            begin
                y = OUT_MIN;
                r.sat = 1'b1;
            end
            state_z1[s] = scaled_product(coef_mem[s][SEL_B1], x)
                        - scaled_product(coef_mem[s][SEL_A1], y) + state_z2[s];
            state_z2[s] = scaled_product(coef_mem[s][SEL_B2], x)
                        - scaled_product(coef_mem[s][SEL_A2], y);
            x = y;
        end
        r.smp = x[SAMPLE_BITS-1:0];
        return r;
    endfunction

    task automatic record_item(input stim_t it);
        filtered_t r;
        case (it.kind)
            KIND_SAMPLE:
            begin
                r = filter_sample(it.smp);
                if (it.typed)
                begin
                    r.smp = it.want;
                    r.sat = it.want_sat;
                end
                pending_q.insert(pending_q.size(), r);
            end
            KIND_COEF:
                if (it.sel <= SEL_A2)
                    coef_mem[it.stage][it.sel] = longint'(it.value);
            KIND_CLEAR:
                for (int s = 0; s < STAGES; s++)
                begin
                    state_z1[s] = 0;
                    state_z2[s] = 0;
                end
            default: ;
        endcase
    endtask

    task automatic add_row(input stim_t r);
        directed_rows.insert(directed_rows.size(), r);
    endtask

    function automatic stim_t sample_row(input int smp, input int typed, input int y,
                                         input int sat);
        stim_t r;
        r = '{KIND_SAMPLE, smp[SAMPLE_BITS-1:0], '0, SEL_B0, '0, typed != 0,
              y[SAMPLE_BITS-1:0], sat != 0};
        return r;
    endfunction

    function automatic stim_t coef_row(input int st, input logic [SEL_W-1:0] sel, input int val);
        stim_t r;
        r = '{KIND_COEF, '0, st[STAGE_IN_W-1:0], sel, val[COEF_BITS-1:0], 1'b0, '0, 1'b0};
        return r;
    endfunction

    function automatic stim_t other_row(input logic [KIND_W-1:0] k);
        stim_t r;
        r = '{k, 16'sh5a5a, 3'd5, SEL_TOP, 20'sh5a5a5, 1'b0, '0, 1'b0};
        return r;
    endfunction

    function automatic stim_t random_item();
        stim_t r;
        int    pick;
        r = '{KIND_SAMPLE, SAMPLE_BITS'($urandom()), STAGE_IN_W'($urandom()),
              SEL_W'($urandom()), COEF_BITS'($urandom()), 1'b0, '0, 1'b0};
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            r.kind = KIND_SAMPLE;
            case ($urandom_range(0, 9))
                0: r.smp = 16'sh7fff;
                1: r.smp = 16'sh8000;
                2: r.smp = SAMPLE_BITS'($urandom_range(0, 511) - 256);
                default: r.smp = SAMPLE_BITS'($urandom());
            endcase
        end
        else if (pick < 90)
        begin
            r.kind = KIND_COEF;
            r.stage = STAGE_IN_W'($urandom_range(0, STAGES - 1));
            r.sel = SEL_W'(($urandom_range(0, 9) == 0) ? $urandom_range(SEL_A2 + 1, SEL_TOP)
                                                        : $urandom_range(SEL_B0, SEL_A2));
            if ($urandom_range(0, 1) == 0)
                r.value = COEF_BITS'($urandom_range(0, 65535) - 32768);
        end
        else if (pick < 96)
            r.kind = KIND_CLEAR;
        else
            r.kind = KIND_IGNORED;
        return r;
    endfunction

    task automatic send_item(input stim_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        kind        <= it.kind;
        sample_in   <= it.smp;
        stage_index <= it.stage;
        coef_select <= it.sel;
        coef_value  <= it.value;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        record_item(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] a,
                              input logic [PDATA_W-1:0] d, output logic [PDATA_W-1:0] q);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        q = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_stages(input int value, input bit poke_unused);
        logic [PDATA_W-1:0] d;
        logic [PDATA_W-1:0] q;
        d = ($urandom() & ~PDATA_W'(15)) | PDATA_W'(value);
        apb_access(1'b1, ADDR_ACTIVE_STAGES, d, q);
        stage_cfg = d[ACTIVE_W-1:0];
        if (poke_unused)
            apb_access(1'b1, ADDR_UNUSED, ~d, q);
        apb_access(1'b0, ADDR_ACTIVE_STAGES, '0, q);
        if (q !== PDATA_W'(stage_cfg))
        begin
            $error("active_stages: expected %0d, got %0d", stage_cfg, q);
            failures++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        filtered_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: sample_out %0d saturated %0b", sample_out, saturated);
                failures++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (sample_out !== e.smp)
                begin
                    $error("sample_out: expected %0d, got %0d", e.smp, sample_out);
                    failures++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated: expected %0b, got %0b", e.sat, saturated);
                    failures++;
                end
            end
        end
    end

    // receiver stall pattern: quiet stretches, random stalls, long blocks
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(20, 200);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 1) == 1);
                default:
                    if (hold_left == 0)
                    begin
                        out_stall <= ~out_stall;
                        hold_left <= out_stall ? $urandom_range(1, 8) : $urandom_range(5, 40);
                    end
                    else
                        hold_left <= hold_left - 1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int fixed_settings [6];
        int counted;
        stim_t it;
        fixed_settings = '{0, 15, 8, 1, 2, 9};
        for (int s = 0; s < STAGES; s++)
        begin
            for (int c = 0; c < NUM_COEFS; c++)
                coef_mem[s][c] = 0;
            state_z1[s] = 0;
            state_z2[s] = 0;
        end
        stage_cfg = 4'd1;

        // one section after reset; b0 extremes give obvious outputs, then bad selects, b1, clear, a1/a2
        add_row(sample_row(0, 1, 0, 0));
        add_row(sample_row(32767, 1, 0, 0));
        add_row(sample_row(-32768, 1, 0, 0));
        add_row(coef_row(0, SEL_B0, 524287));
        add_row(sample_row(32767, 1, 32767, 1));
        add_row(sample_row(-32768, 1, -32768, 1));
        add_row(coef_row(0, SEL_B0, -524288));
        add_row(sample_row(32767, 1, -32768, 1));
        add_row(sample_row(-32768, 1, 32767, 1));
        add_row(coef_row(0, SEL_B0, 65536));
        add_row(sample_row(12345, 1, 12345, 0));
        add_row(sample_row(-32768, 1, -32768, 0));
        add_row(coef_row(0, SEL_W'(SEL_A2 + 1), 0));
        add_row(coef_row(0, SEL_TOP, 0));
        add_row(other_row(KIND_IGNORED));
        add_row(sample_row(32767, 1, 32767, 0));
        add_row(sample_row(-1, 1, -1, 0));
        add_row(coef_row(0, SEL_B1, 524287));
        add_row(sample_row(1000, 0, 0, 0));
        add_row(sample_row(0, 0, 0, 0));
        add_row(other_row(KIND_CLEAR));
        add_row(sample_row(0, 1, 0, 0));
        add_row(coef_row(0, SEL_A1, -524288));
        add_row(coef_row(0, SEL_A2, 524287));
        add_row(coef_row(STAGES - 1, SEL_B2, 1));
        add_row(sample_row(20000, 0, 0, 0));
        add_row(sample_row(-20000, 0, 0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 6)
                set_stages(fixed_settings[phase], phase == 3);
            else
                set_stages($urandom_range(0, 15), 1'b0);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                it = random_item();
                send_item(it);
                if (it.kind != KIND_IGNORED)
                    counted++;
                if (phase == 2 && counted == PHASE_ITEMS / 2)
                    drain();
            end
            drain();
        end

        if (pending_q.size() != 0)
        begin
            $error("%0d filtered samples never arrived", pending_q.size());
            failures++;
        end
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
